>>> rtl/core/gyro_shake_detector_defines.svh
// assertion macros for the shake detector
`ifndef GYRO_SHAKE_DETECTOR_DEFINES_SVH
`define GYRO_SHAKE_DETECTOR_DEFINES_SVH

// implication checked at every edge outside reset
`define GSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define GSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gsd_pkg.sv
// ---------------------------------------------------------------------------
// gsd_pkg
// shared constants and types of the shake detector
// ---------------------------------------------------------------------------
`default_nettype none
package gsd_pkg;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int TIME_W  = 63;
    localparam int CFG_W   = 40;
    localparam int LEVEL_W = 16;
    localparam int PROG_W  = 17;
    localparam int SUM_W   = 26;
    localparam int MIN_USED = 8;

    localparam logic [1:0] KIND_IDLE     = 2'd0;
    localparam logic [1:0] KIND_BUILDING = 2'd1;
    localparam logic [1:0] KIND_TRIGGER  = 2'd2;

    localparam logic [1:0] REG_SENS     = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN  = 2'd2;
    localparam logic [1:0] REG_COOLDOWN = 2'd3;

    localparam logic [8:0]  SENS_RST     = 9'd128;
    localparam logic [39:0] WINDOW_RST   = 40'd2000000000;
    localparam logic [39:0] SUSTAIN_RST  = 40'd8000000000;
    localparam logic [39:0] COOLDOWN_RST = 40'd60000000000;

    // divider request
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> rtl/core/gyro_shake_detector.sv
// ---------------------------------------------------------------------------
// gyro_shake_detector
// sustained-shake detector on a stream of gyro samples
// input channel: i_valid/o_stall with sample_time_ns and three Q8.8 rates
// output channel: o_valid/i_stall with detection_kind, peak_level,
// sustained_ns and progress, one result per accepted request
// config channel: i_cfg_valid/o_cfg_ready, index and 40-bit data, taken
// while the sequencer is idle
// from acceptance to o_valid the sequencer squares the three rates, takes a
// bit-pair square root, writes the ring and walks the ring entries in the
// window, then outputs; with 8 or more entries it first runs the mean divide
// and an evaluate step, and a building result with a non-negative duration
// below sustain adds a progress divide
// o_stall stays high from acceptance until the result has been taken, so
// the next request is accepted only once the taken result has cleared o_valid
// a stalled result waits unchanged in its register
// reset (synchronous, active low) loads the register defaults and clears
// ring head, fill count and episode state; ring contents are not cleared
// ---------------------------------------------------------------------------
`default_nettype none
module gyro_shake_detector #(
    parameter int WINDOW_DEPTH = gsd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [62:0] i_sample_time_ns,
    input  wire logic signed [15:0] i_rate_x,
    input  wire logic signed [15:0] i_rate_y,
    input  wire logic signed [15:0] i_rate_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_detection_kind,
    output logic [15:0]      o_peak_level,
    output logic [62:0]      o_sustained_ns,
    output logic [16:0]      o_progress,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [39:0] i_cfg_data
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] FULL = FW'(WINDOW_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SQ    = 10'b0000000010,
        S_SQRT  = 10'b0000000100,
        S_WRITE = 10'b0000001000,
        S_RD    = 10'b0000010000,
        S_ACC   = 10'b0000100000,
        S_MEAN  = 10'b0001000000,
        S_EVAL  = 10'b0010000000,
        S_PROG  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [8:0]  r_sens;
    logic [39:0] r_window, r_sustain, r_cooldown;

    logic [62:0] r_now;
    logic [15:0] r_ax, r_ay, r_az;
    logic [33:0] r_sq;
    logic [33:0] r_rad;
    logic [17:0] r_root;
    logic [3:0]  r_sqi;
    logic [1:0]  r_sqs;

    logic [AW-1:0] r_head, r_idx;
    logic [FW-1:0] r_fill, r_walk, r_used;
    logic [gsd_pkg::SUM_W-1:0] r_sum;
    logic [15:0] r_mean;

    logic [62:0] r_ep_start;
    logic [15:0] r_ep_peak;
    logic [62:0] r_last_trig;
    logic [62:0] r_dur;

    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [15:0] r_opeak;
    logic [62:0] r_osus;
    logic [16:0] r_oprog;

    gsd_pkg::t_div_req div_req;
    gsd_pkg::t_div_rsp div_rsp;

    logic [62:0] rd_time;
    logic [15:0] rd_level;
    logic        ring_we;

    gsd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    gsd_ring #(.DEPTH(WINDOW_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_head),
        .i_wtime (r_now),
        .i_wlevel(r_root[15:0]),
        .i_raddr (r_idx),
        .o_rtime (rd_time),
        .o_rlevel(rd_level)
    );

    logic        in_acc;
    logic [15:0] sq_op;
    logic [31:0] sq_prod;
    logic [33:0] trial;
    logic [33:0] rad_sh;
    logic [62:0] age;
    logic        outside;
    logic [8:0]  sens_c;
    logic [11:0] thresh;
    logic        neg;
    logic [62:0] dur_c;
    logic        past_cd;
    logic [62:0] cd_age;

    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign ring_we     = (r_state == S_WRITE);

    always_comb begin
        unique case (r_sqs)
            2'd0:    sq_op = r_ax;
            2'd1:    sq_op = r_ay;
            default: sq_op = r_az;
        endcase
        sq_prod = 32'(sq_op) * 32'(sq_op);
        rad_sh  = {r_rad[31:0], r_sq[31 - 2*r_sqi -: 2]};
        trial   = rad_sh - {14'd0, r_root, 2'b01};
        age     = r_now - rd_time;
        outside = (r_now >= rd_time) && (age > {23'd0, r_window});
        sens_c  = (r_sens > 9'd256) ? 9'd256 : r_sens;
        thresh  = 12'd3072 - 12'({sens_c, 3'b000} + {3'b000, sens_c});
        neg     = r_now < r_ep_start;
        dur_c   = r_now - r_ep_start;
        cd_age  = r_now - r_last_trig;
        past_cd = (r_now >= r_last_trig) && (cd_age >= {23'd0, r_cooldown});
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = 64'd1;
        n_state       = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_SQ;
            S_SQ:    if (r_sqs == 2'd2) n_state = S_SQRT;
            S_SQRT:  if (r_sqi == 4'd15) n_state = S_WRITE;
            S_WRITE: n_state = S_RD;
            S_RD:    n_state = S_ACC;
            S_ACC: begin
                if (outside || r_walk == '0) begin
                    if (r_used < FW'(gsd_pkg::MIN_USED)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MEAN;
                        div_req.start = 1'b1;
                        div_req.num = 64'(r_sum);
                        div_req.den = 64'(r_used);
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_MEAN:  if (div_rsp.done) n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_OUT;
                if (r_mean >= {4'd0, thresh} && !neg && r_dur < {23'd0, r_sustain}) begin
                    n_state = S_PROG;
                    div_req.start = 1'b1;
                    div_req.num = {1'b0, r_dur[46:0], 16'd0};
                    div_req.den = {24'd0, r_sustain};
                end
            end
            S_PROG:  if (div_rsp.done) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sens      <= gsd_pkg::SENS_RST;
            r_window    <= gsd_pkg::WINDOW_RST;
            r_sustain   <= gsd_pkg::SUSTAIN_RST;
            r_cooldown  <= gsd_pkg::COOLDOWN_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_ep_start  <= '0;
            r_ep_peak   <= '0;
            r_last_trig <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    gsd_pkg::REG_SENS:     r_sens     <= i_cfg_data[8:0];
                    gsd_pkg::REG_WINDOW:   r_window   <= i_cfg_data;
                    gsd_pkg::REG_SUSTAIN:  r_sustain  <= i_cfg_data;
                    gsd_pkg::REG_COOLDOWN: r_cooldown <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now <= i_sample_time_ns;
                        r_ax  <= i_rate_x[15] ? 16'(-i_rate_x) : i_rate_x;
                        r_ay  <= i_rate_y[15] ? 16'(-i_rate_y) : i_rate_y;
                        r_az  <= i_rate_z[15] ? 16'(-i_rate_z) : i_rate_z;
                        r_sq  <= '0;
                        r_sqs <= '0;
                    end
                end
                S_SQ: begin
                    r_sq  <= r_sq + 34'(sq_prod);
                    r_sqs <= r_sqs + 2'd1;
                    r_rad <= '0;
                    r_root <= '0;
                    r_sqi <= '0;
                end
                S_SQRT: begin
                    if (!trial[33]) begin
                        r_rad  <= trial;
                        r_root <= {r_root[16:0], 1'b1};
                    end else begin
                        r_rad  <= rad_sh;
                        r_root <= {r_root[16:0], 1'b0};
                    end
                    r_sqi <= r_sqi + 4'd1;
                end
                S_WRITE: begin
                    r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
                    r_idx  <= r_head;
                    r_walk <= (r_fill == FULL) ? FULL : r_fill + FW'(1);
                    if (r_fill != FULL) r_fill <= r_fill + FW'(1);
                    r_sum  <= '0;
                    r_used <= '0;
                end
                S_RD: ;
                S_ACC: begin
                    if (!(outside || r_walk == '0)) begin
                        r_sum  <= r_sum + gsd_pkg::SUM_W'(rd_level);
                        r_used <= r_used + FW'(1);
                        r_walk <= r_walk - FW'(1);
                        r_idx  <= (r_idx == '0) ? LAST : r_idx - AW'(1);
                    end
                    r_kind  <= gsd_pkg::KIND_IDLE;
                    r_opeak <= '0;
                    r_osus  <= '0;
                    r_oprog <= '0;
                end
                S_MEAN: begin
                    if (div_rsp.done) begin
                        r_mean <= div_rsp.quo[15:0];
                        if (div_rsp.quo[15:0] >= {4'd0, thresh}) begin
                            if (r_ep_start == '0) begin
                                r_ep_start <= r_now;
                                r_dur      <= '0;
                            end else begin
                                r_dur <= dur_c;
                            end
                            if (div_rsp.quo[15:0] > r_ep_peak) r_ep_peak <= div_rsp.quo[15:0];
                        end else begin
                            r_ep_start <= '0;
                            r_ep_peak  <= '0;
                        end
                    end
                end
                S_EVAL: begin
                    if (r_mean >= {4'd0, thresh}) begin
                        if (!neg && r_dur >= {23'd0, r_sustain} && past_cd) begin
                            r_last_trig <= r_now;
                            r_kind      <= gsd_pkg::KIND_TRIGGER;
                            r_opeak     <= r_ep_peak;
                            r_osus      <= r_dur;
                            r_ep_start  <= '0;
                            r_ep_peak   <= '0;
                        end else begin
                            r_kind  <= gsd_pkg::KIND_BUILDING;
                            r_oprog <= neg ? 17'd0 : 17'd65536;
                        end
                    end
                end
                S_PROG: if (div_rsp.done) r_oprog <= div_rsp.quo[16:0];
                S_OUT:  r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_detection_kind = r_kind;
    assign o_peak_level     = r_opeak;
    assign o_sustained_ns   = r_osus;
    assign o_progress       = r_oprog;
endmodule
`default_nettype wire

>>> rtl/core/gsd_div.sv
// ---------------------------------------------------------------------------
// gsd_div
// shared radix-2 restoring divider, 64 bits, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module gsd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gsd_pkg::t_div_req i_req,
    output gsd_pkg::t_div_rsp      o_rsp
);
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        shifted = {r_rem, r_quo[63]};
        diff    = shifted - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[64]) begin
                n_rem = diff[63:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = shifted[63:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

>>> rtl/core/gsd_ring.sv
// ---------------------------------------------------------------------------
// gsd_ring
// sample ring memory of timestamps and levels, registered read
// ---------------------------------------------------------------------------
`default_nettype none
module gsd_ring #(
    parameter int DEPTH = gsd_pkg::WINDOW_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [gsd_pkg::TIME_W-1:0]   i_wtime,
    input  wire logic [gsd_pkg::LEVEL_W-1:0]  i_wlevel,
    input  wire logic [AW-1:0]                i_raddr,
    output logic [gsd_pkg::TIME_W-1:0]        o_rtime,
    output logic [gsd_pkg::LEVEL_W-1:0]       o_rlevel
);
    logic [gsd_pkg::TIME_W+gsd_pkg::LEVEL_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wtime, i_wlevel};
        end
        {o_rtime, o_rlevel} <= mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/gsd_checker.sv
// ---------------------------------------------------------------------------
// gsd_checker
// port-level checks of the shake detector
// ---------------------------------------------------------------------------
`default_nettype none
`include "gyro_shake_detector_defines.svh"
module gsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_detection_kind,
    input wire logic [15:0] o_peak_level,
    input wire logic [16:0] o_progress,
    input wire logic        o_cfg_ready
);
    `GSD_ASSERT_IMP(a_kind, i_clk, i_rst_n, o_valid, o_detection_kind != 2'd3, "bad kind")
    `GSD_ASSERT_IMP(a_prog, i_clk, i_rst_n, o_valid && o_detection_kind != gsd_pkg::KIND_BUILDING, o_progress == 17'd0, "progress outside building")
    `GSD_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall && !o_cfg_ready, "not busy after request")
    `GSD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_peak_level), "result dropped")
endmodule
`default_nettype wire

bind gyro_shake_detector gsd_checker u_gsd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_detection_kind(o_detection_kind),
    .o_peak_level(o_peak_level), .o_progress(o_progress), .o_cfg_ready(o_cfg_ready)
);

>>> dv/tb_gyro_shake_detector.sv
// ---------------------------------------------------------------------------
// tb_gyro_shake_detector
// self-checking bench: directed table then random gyro sample streams with
// config phases, each result compared against a behavioral shake predictor
// ---------------------------------------------------------------------------
`default_nettype none
module tb_gyro_shake_detector;

    localparam int DEPTH = gsd_pkg::WINDOW_DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RAND = 1650;

    typedef struct packed {
        logic [62:0] t;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_sample;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] peak;
        logic [62:0] sus;
        logic [16:0] prog;
    } t_detect;

    typedef struct {
        t_sample s;
        logic    chk;
        t_detect d;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [62:0] i_sample_time_ns = '0;
    logic signed [15:0] i_rate_x = '0;
    logic signed [15:0] i_rate_y = '0;
    logic signed [15:0] i_rate_z = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_detection_kind;
    logic [15:0] o_peak_level;
    logic [62:0] o_sustained_ns;
    logic [16:0] o_progress;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [39:0] i_cfg_data = '0;

    gyro_shake_detector dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [8:0]  m_sens;
    logic [39:0] m_window, m_sustain, m_cooldown;
    logic [62:0] m_times [DEPTH];
    logic [15:0] m_levels [DEPTH];
    int          m_head, m_fill;
    logic [62:0] m_ep_start, m_last_trig;
    logic [15:0] m_ep_peak;

    t_detect expected_q [$];
    int  errors = 0;
    int  wdog = 0;
    bit  hold_off = 1'b0;
    bit  rand_go = 1'b0;
    bit  rx_chk [$];
    t_detect rx_fix [$];

    function automatic logic [31:0] rate_abs(logic [15:0] r);
        return r[15] ? 32'(17'h10000 - {1'b0, r}) : 32'(r);
    endfunction

    function automatic logic [15:0] mag_sqrt(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res[15:0];
    endfunction

    task automatic model_reset();
        m_sens = gsd_pkg::SENS_RST;
        m_window = gsd_pkg::WINDOW_RST;
        m_sustain = gsd_pkg::SUSTAIN_RST;
        m_cooldown = gsd_pkg::COOLDOWN_RST;
        m_head = 0;
        m_fill = 0;
        m_ep_start = '0;
        m_ep_peak = '0;
        m_last_trig = '0;
    endtask

    function automatic t_detect predict_detect(t_sample s);
        t_detect d;
        logic [63:0] ax, ay, az, sum, mean, thr, sens, dur, num;
        int used, idx;
        bit neg, past;
        d = '0;
        ax = rate_abs(s.x);
        ay = rate_abs(s.y);
        az = rate_abs(s.z);
        m_times[m_head] = s.t;
        m_levels[m_head] = mag_sqrt(ax * ax + ay * ay + az * az);
        m_head = (m_head + 1 >= DEPTH) ? 0 : m_head + 1;
        if (m_fill < DEPTH) m_fill++;
        idx = m_head;
        sum = 0;
        used = 0;
        for (int i = 0; i < m_fill; i++) begin
            idx = (idx == 0) ? DEPTH - 1 : idx - 1;
            if (s.t >= m_times[idx] && 64'(s.t - m_times[idx]) > 64'(m_window)) break;
            sum += m_levels[idx];
            used++;
        end
        if (used < gsd_pkg::MIN_USED) return d;
        mean = sum / used;
        sens = (m_sens > 256) ? 256 : m_sens;
        thr = 3072 - 9 * sens;
        if (mean >= thr) begin
            if (m_ep_start == 0) m_ep_start = s.t;
            if (mean > m_ep_peak) m_ep_peak = mean[15:0];
            neg = s.t < m_ep_start;
            dur = neg ? 0 : 64'(s.t - m_ep_start);
            past = s.t >= m_last_trig && 64'(s.t - m_last_trig) >= 64'(m_cooldown);
            if (!neg && dur >= m_sustain && past) begin
                m_last_trig = s.t;
                d.kind = gsd_pkg::KIND_TRIGGER;
                d.peak = m_ep_peak;
                d.sus = dur[62:0];
                m_ep_start = '0;
                m_ep_peak = '0;
            end else begin
                d.kind = gsd_pkg::KIND_BUILDING;
                if (neg) d.prog = 0;
                else if (dur >= m_sustain) d.prog = 17'h10000;
                else begin
                    num = dur << 16;
                    d.prog = 17'(num / m_sustain);
                end
            end
        end else begin
            m_ep_start = '0;
            m_ep_peak = '0;
        end
        return d;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [39:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            gsd_pkg::REG_SENS:     m_sens = val[8:0];
            gsd_pkg::REG_WINDOW:   m_window = val;
            gsd_pkg::REG_SUSTAIN:  m_sustain = val;
            gsd_pkg::REG_COOLDOWN: m_cooldown = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_sample(t_sample s, bit chk, t_detect fix);
        t_detect d;
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        d = predict_detect(s);
        expected_q.push_back(d);
        rx_chk.push_back(chk);
        rx_fix.push_back(fix);
        i_sample_time_ns <= s.t;
        i_rate_x <= s.x;
        i_rate_y <= s.y;
        i_rate_z <= s.z;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [15:0] rand_rate(int amp);
        return 16'($signed($urandom_range(0, 2 * amp)) - amp);
    endfunction

    // receiver
    initial begin
        t_detect e, f;
        bit c;
        int idle_n;
        idle_n = $urandom_range(0, 7);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result kind %0d", $time, o_detection_kind);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    c = rx_chk.pop_front();
                    f = rx_fix.pop_front();
                    if (c && f != e) begin
                        $display("%0t: table row exp %h model %h", $time, f, e);
                        errors++;
                    end
                    if (o_detection_kind != e.kind) begin
                        $display("%0t: kind exp %0d act %0d", $time, e.kind,
                                 o_detection_kind);
                        errors++;
                    end
                    if (o_peak_level != e.peak) begin
                        $display("%0t: peak exp %0d act %0d", $time, e.peak, o_peak_level);
                        errors++;
                    end
                    if (o_sustained_ns != e.sus) begin
                        $display("%0t: sustained exp %0d act %0d", $time, e.sus,
                                 o_sustained_ns);
                        errors++;
                    end
                    if (o_progress != e.prog) begin
                        $display("%0t: progress exp %0d act %0d", $time, e.prog,
                                 o_progress);
                        errors++;
                    end
                end
                idle_n = $urandom_range(0, 7);
            end else if (o_valid && idle_n != 0 && !hold_off) begin
                idle_n--;
            end
            i_stall <= hold_off || (idle_n != 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n || hold_off)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // long receiver hold-off during the random stream, stalling the samples behind it
    initial begin
        wait (rand_go);
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    t_row dir_tab [] = '{
        // too few samples after reset: idle, until the eighth sample is evaluated
        '{'{63'd1000, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b1, '0},
        '{'{63'd2000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, '0},
        '{'{63'd3000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '0},
        '{'{63'd4000, 16'h8000, 16'h7fff, 16'h0001}, 1'b1, '0},
        '{'{63'd5000, 16'hffff, 16'h0000, 16'h8000}, 1'b1, '0},
        '{'{63'd6000, 16'h7fff, 16'h8000, 16'h7fff}, 1'b1, '0},
        '{'{63'd7000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, '0},
        '{'{63'd8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{63'd9000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        // time running backwards
        '{'{63'd10, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{63'd0, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{63'h7fffffffffffffff, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{63'd20000, 16'h0100, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{63'd30000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{63'h7fffffffffffffff, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0}
    };

    initial begin
        t_sample s;
        logic [62:0] now;
        int amp, burst;
        model_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < dir_tab.size(); r++)
            send_sample(dir_tab[r].s, dir_tab[r].chk, dir_tab[r].d);
        drain();

        // extremes of every register, zero sustain, zero cooldown
        cfg_write(gsd_pkg::REG_SENS, 40'd511);
        cfg_write(gsd_pkg::REG_WINDOW, 40'hffffffffff);
        cfg_write(gsd_pkg::REG_SUSTAIN, 40'd0);
        cfg_write(gsd_pkg::REG_COOLDOWN, 40'd0);
        for (int i = 0; i < 20; i++) begin
            s.t = 63'(100 + i * 10);
            s.x = 16'h4000; s.y = 16'h0; s.z = 16'h0;
            send_sample(s, 1'b0, '0);
        end
        drain();

        rand_go = 1'b1;
        now = 63'd1;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin
                    cfg_write(gsd_pkg::REG_SENS, 40'($urandom_range(0, 511)));
                    cfg_write(gsd_pkg::REG_WINDOW, 40'($urandom_range(50000, 400000)));
                    cfg_write(gsd_pkg::REG_SUSTAIN, 40'($urandom_range(0, 2000000)));
                    cfg_write(gsd_pkg::REG_COOLDOWN, 40'($urandom_range(0, 3000000)));
                end
                1: begin
                    cfg_write(gsd_pkg::REG_SENS, 40'd0);
                    cfg_write(gsd_pkg::REG_WINDOW, 40'd0);
                    cfg_write(gsd_pkg::REG_SUSTAIN, 40'hffffffffff);
                    cfg_write(gsd_pkg::REG_COOLDOWN, 40'hffffffffff);
                end
                2: begin
                    cfg_write(gsd_pkg::REG_SENS, 40'd256);
                    cfg_write(gsd_pkg::REG_WINDOW, 40'hffffffffff);
                    cfg_write(gsd_pkg::REG_SUSTAIN, 40'd300000);
                    cfg_write(gsd_pkg::REG_COOLDOWN, 40'd0);
                end
                default: begin
                    cfg_write(gsd_pkg::REG_SENS, 40'($urandom_range(100, 256)));
                    cfg_write(gsd_pkg::REG_WINDOW, 40'($urandom_range(100000, 200000)));
                    cfg_write(gsd_pkg::REG_SUSTAIN, 40'($urandom_range(100000, 800000)));
                    cfg_write(gsd_pkg::REG_COOLDOWN, 40'($urandom_range(0, 1500000)));
                end
            endcase
            for (int i = 0; i < N_RAND / 10; ) begin
                // bursts of quiet or shaking with timestamps rising by random steps, some noise
                amp = ($urandom_range(0, 1) == 1) ? 32767 : $urandom_range(0, 1500);
                burst = $urandom_range(4, 40);
                for (int k = 0; k < burst && i < N_RAND / 10; k++, i++) begin
                    if ($urandom_range(0, 30) == 0)
                        s.t = 63'({$urandom, $urandom});
                    else if ($urandom_range(0, 30) == 0)
                        s.t = now - 63'($urandom_range(0, 50000));
                    else begin
                        now = now + 63'($urandom_range(1000, 20000));
                        s.t = now;
                    end
                    s.x = rand_rate(amp);
                    s.y = rand_rate(amp);
                    s.z = rand_rate(amp);
                    send_sample(s, 1'b0, '0);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> gyro_shake_detector.f
+incdir+rtl/core
rtl/core/gsd_pkg.sv
rtl/core/gsd_div.sv
rtl/core/gsd_ring.sv
rtl/core/gyro_shake_detector.sv
rtl/core/gsd_checker.sv
dv/tb_gyro_shake_detector.sv
